>>> hw/rtl/ppd_pkg.sv
// shared types, constants and the phase/voltage breakpoint table of the duty converter
package ppd_pkg;

  localparam int TABLE_ENTRIES = 54;
  localparam int TABLE_ROWS    = 64;
  localparam int IDX_W         = $clog2(TABLE_ROWS);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_SCAN_END = IDX_W'(TABLE_ENTRIES - 2);

  localparam int PHASE_W = 16;
  localparam int VOLT_W  = 15;
  localparam int FRAC_W  = 24;
  localparam int COUNT_W = 16;
  localparam int FLAG_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DX_W   = PHASE_W + 1;        // phase difference magnitude
  localparam int NUM_W  = 32;                 // |dx * dy| magnitude
  localparam int CNT_W  = $clog2(NUM_W);      // divider step counter
  localparam int VACC_W = VOLT_W + 3;         // signed interpolated voltage
  localparam int M1_W   = VOLT_W + FRAC_W;
  localparam int M1_LO  = 20;
  localparam int M1_HI  = M1_W - M1_LO;
  localparam int SUM_W  = M1_W + COUNT_W;
  localparam int SHIFT  = 34;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULLSCALE = 2'd2;

  localparam logic [VOLT_W-1:0]  CEILING_RST   = 15'd19149;
  localparam logic [FRAC_W-1:0]  FRACTION_RST  = 24'd841724;
  localparam logic [COUNT_W-1:0] FULLSCALE_RST = 16'd1024;

  // range codes
  localparam logic [FLAG_W-1:0] RANGE_INTERP = 2'd0;
  localparam logic [FLAG_W-1:0] RANGE_BELOW  = 2'd1;
  localparam logic [FLAG_W-1:0] RANGE_ABOVE  = 2'd2;

  localparam logic signed [PHASE_W-1:0] PHASE_TAB [TABLE_ROWS] = '{
    -16'sd21055, -16'sd20755, -16'sd20650, -16'sd20308,
    -16'sd20093, -16'sd19720, -16'sd19231, -16'sd18279,
    -16'sd16098, -16'sd15944, -16'sd15432, -16'sd14044,
    -16'sd12954, -16'sd10200, -16'sd7385,  -16'sd454,
    16'sd5868,  16'sd7247,  16'sd10837, 16'sd12569, 16'sd14164, 16'sd15140, 16'sd16465, 16'sd16880,
    16'sd17581, 16'sd17784, 16'sd18471, 16'sd18748, 16'sd19061, 16'sd19189, 16'sd19444, 16'sd19536,
    16'sd19728, 16'sd19807, 16'sd19993, 16'sd20030, 16'sd20173, 16'sd20226, 16'sd20332, 16'sd20419,
    16'sd20446, 16'sd20615, 16'sd20639, 16'sd20744, 16'sd20787, 16'sd20820, 16'sd20908, 16'sd20930,
    16'sd20995, 16'sd21027, 16'sd21005, 16'sd21034, 16'sd21040, 16'sd21055,
    16'sd21055, 16'sd21055, 16'sd21055, 16'sd21055, 16'sd21055,
    16'sd21055, 16'sd21055, 16'sd21055, 16'sd21055, 16'sd21055
  };

  localparam logic [VOLT_W-1:0] VOLT_TAB [TABLE_ROWS] = '{
    15'd0,     15'd1024,  15'd2048,  15'd3072,  15'd4096,  15'd5120,  15'd6144,  15'd7168,
    15'd8192,  15'd8294,  15'd8397,  15'd8704,  15'd8909,  15'd9216,  15'd9421,  15'd9728,
    15'd9933,  15'd10035, 15'd10240, 15'd10445, 15'd10752, 15'd10957, 15'd11264, 15'd11469,
    15'd11776, 15'd11981, 15'd12288, 15'd12493, 15'd12800, 15'd13005, 15'd13312, 15'd13517,
    15'd13824, 15'd14029, 15'd14336, 15'd14541, 15'd14848, 15'd15053, 15'd15360, 15'd15565,
    15'd15872, 15'd16077, 15'd16384, 15'd16589, 15'd16896, 15'd17101, 15'd17408, 15'd17613,
    15'd17920, 15'd18125, 15'd18432, 15'd18637, 15'd18944, 15'd19149,
    15'd19149, 15'd19149, 15'd19149, 15'd19149, 15'd19149,
    15'd19149, 15'd19149, 15'd19149, 15'd19149, 15'd19149
  };

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_PREP, S_DIV, S_FIXUP,
    S_CLAMP, S_MUL1, S_MUL2, S_MUL3, S_FINISH
  } ppd_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic prep;
    logic div_step;
    logic fixup;
    logic clamp;
    logic mul1;
    logic mul2;
    logic mul3;
    logic out_load;
  } ppd_cmd_t;

  typedef struct packed {
    logic edge_hit;   // phase at or beyond either end of the table
    logic match;
    logic scan_last;
    logic den_zero;
    logic div_last;
  } ppd_status_t;

endpackage

>>> hw/rtl/ppd_ctrl.sv
// sequencing state machine of the duty converter
module ppd_ctrl import ppd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ppd_status_t st,
  output ppd_cmd_t    cmd
);

  ppd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = st.edge_hit ? S_CLAMP : S_SCAN;
      S_SCAN: begin
        priority if (st.match)     state_nxt = S_PREP;
        else if (st.scan_last)     state_nxt = S_CLAMP;
        else                       state_nxt = S_SCAN;
      end
      S_PREP:   state_nxt = st.den_zero ? S_CLAMP : S_DIV;
      S_DIV:    if (st.div_last) state_nxt = S_FIXUP;
      S_FIXUP:  state_nxt = S_CLAMP;
      S_CLAMP:  state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_MUL3;
      S_MUL3:   state_nxt = S_FINISH;
      S_FINISH: if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK:  cmd.check    = 1'b1;
      S_SCAN:   cmd.scan     = 1'b1;
      S_PREP:   cmd.prep     = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_FIXUP:  cmd.fixup    = 1'b1;
      S_CLAMP:  cmd.clamp    = 1'b1;
      S_MUL1:   cmd.mul1     = 1'b1;
      S_MUL2:   cmd.mul2     = 1'b1;
      S_MUL3:   cmd.mul3     = 1'b1;
      S_FINISH: cmd.out_load = slot_free;
      default:  cmd          = '0;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/ppd_dpath.sv
// datapath: config registers, table scan, serial divider, scaling multipliers, result register
module ppd_dpath import ppd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ppd_cmd_t                  cmd,
  output ppd_status_t               st,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [PHASE_W-1:0] in_phase,
  output logic [VOLT_W-1:0]         out_voltage,
  output logic [COUNT_W-1:0]        out_duty_count,
  output logic [FLAG_W-1:0]         out_range_flag
);

  logic [VOLT_W-1:0]  ceiling_r;
  logic [FRAC_W-1:0]  fraction_r;
  logic [COUNT_W-1:0] fullscale_r;

  logic signed [PHASE_W-1:0] phase_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [VACC_W-1:0]  vacc_r;
  logic [FLAG_W-1:0]         flag_r;
  logic [VOLT_W-1:0]         ybase_r;
  logic                      neg_r;
  logic [DX_W-1:0]           den_r;
  logic [NUM_W-1:0]          quo_r;
  logic [DX_W-1:0]           rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [VOLT_W-1:0]         vclamp_r;
  logic [M1_W-1:0]           m1_r;
  logic [M1_LO+COUNT_W-1:0]  plo_r;
  logic [M1_HI+COUNT_W-1:0]  phi_r;

  logic signed [PHASE_W-1:0] x_lo, x_hi;
  logic [VOLT_W-1:0]         y_lo, y_hi;
  logic [IDX_W-1:0]          idx_hi;

  logic signed [DX_W:0]          dx_s, den_s;
  logic signed [VOLT_W:0]        dy;
  logic signed [DX_W+VOLT_W+1:0] prod;
  logic [NUM_W-1:0]              mag;
  logic [DX_W:0]                 shifted;
  logic                          fits;
  logic signed [VOLT_W+1:0]      qs;
  logic signed [VACC_W-1:0]      vfix;
  logic [SUM_W-1:0]              total;
  logic [SUM_W-SHIFT-1:0]        count;
  logic [COUNT_W-1:0]            duty;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r   <= CEILING_RST;
      fraction_r  <= FRACTION_RST;
      fullscale_r <= FULLSCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CEILING:   ceiling_r   <= cfg_data[VOLT_W-1:0];
        REG_FRACTION:  fraction_r  <= cfg_data[FRAC_W-1:0];
        REG_FULLSCALE: fullscale_r <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  assign idx_hi = idx_r + IDX_W'(1);
  assign x_lo   = PHASE_TAB[idx_r];
  assign x_hi   = PHASE_TAB[idx_hi];
  assign y_lo   = VOLT_TAB[idx_r];
  assign y_hi   = VOLT_TAB[idx_hi];

  assign st.edge_hit  = (phase_r <= PHASE_TAB[0]) || (phase_r >= PHASE_TAB[IDX_LAST]);
  assign st.match     = (phase_r >= x_lo) && (phase_r <= x_hi);
  assign st.scan_last = (idx_r == IDX_SCAN_END);
  assign st.den_zero  = (x_hi == x_lo);
  assign st.div_last  = (cnt_r == '0);

  // interval set-up: dx is never negative on a matching interval
  assign dx_s  = (DX_W+1)'(phase_r) - (DX_W+1)'(x_lo);
  assign den_s = (DX_W+1)'(x_hi) - (DX_W+1)'(x_lo);
  assign dy    = $signed({1'b0, y_hi}) - $signed({1'b0, y_lo});
  assign prod  = (DX_W+VOLT_W+2)'(dx_s) * (DX_W+VOLT_W+2)'(dy);
  assign mag   = prod[DX_W+VOLT_W+1] ? NUM_W'(-prod) : NUM_W'(prod);

  // restoring divide step
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  // quotient magnitude never exceeds |dy|
  assign qs   = neg_r ? -$signed({1'b0, quo_r[VOLT_W:0]}) : $signed({1'b0, quo_r[VOLT_W:0]});
  assign vfix = $signed({3'b000, ybase_r}) + VACC_W'(qs);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      phase_r <= in_phase;
      idx_r   <= '0;
    end
    if (cmd.check) begin
      priority if (phase_r <= PHASE_TAB[0]) begin
        vacc_r <= VACC_W'(VOLT_TAB[0]);
        flag_r <= RANGE_BELOW;
      end else if (phase_r >= PHASE_TAB[IDX_LAST]) begin
        vacc_r <= VACC_W'(VOLT_TAB[IDX_LAST]);
        flag_r <= RANGE_ABOVE;
      end else begin
        flag_r <= RANGE_INTERP;
      end
    end
    if (cmd.scan && !st.match) begin
      // no interval found falls back to the last entry
      if (st.scan_last) vacc_r <= VACC_W'(VOLT_TAB[IDX_LAST]);
      else              idx_r  <= idx_hi;
    end
    if (cmd.prep) begin
      vacc_r  <= VACC_W'(y_lo);
      ybase_r <= y_lo;
      neg_r   <= prod[DX_W+VOLT_W+1];
      den_r   <= den_s[DX_W-1:0];
      quo_r   <= mag;
      rem_r   <= '0;
      cnt_r   <= CNT_W'(NUM_W - 1);
    end
    if (cmd.div_step) begin
      rem_r <= fits ? DX_W'(shifted - {1'b0, den_r}) : shifted[DX_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.fixup) vacc_r <= vfix;
    if (cmd.clamp) begin
      priority if (vacc_r < 0)                           vclamp_r <= '0;
      else if (vacc_r > $signed({3'b000, ceiling_r}))    vclamp_r <= ceiling_r;
      else                                               vclamp_r <= vacc_r[VOLT_W-1:0];
    end
    if (cmd.mul1) m1_r  <= M1_W'(vclamp_r) * M1_W'(fraction_r);
    if (cmd.mul2) plo_r <= (M1_LO+COUNT_W)'(m1_r[M1_LO-1:0]) * (M1_LO+COUNT_W)'(fullscale_r);
    if (cmd.mul3) phi_r <= (M1_HI+COUNT_W)'(m1_r[M1_W-1:M1_LO]) * (M1_HI+COUNT_W)'(fullscale_r);
  end

  assign total = {phi_r, {M1_LO{1'b0}}} + SUM_W'(plo_r);
  assign count = total[SUM_W-1:SHIFT];
  assign duty  = (count > (SUM_W-SHIFT)'(fullscale_r)) ? fullscale_r : count[COUNT_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_voltage    <= vclamp_r;
      out_duty_count <= duty;
      out_range_flag <= flag_r;
    end
  end

endmodule

>>> hw/rtl/phase_to_pwm_duty_converter.sv
// top level of the phase to pwm duty converter
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_ready   | in_phase (s16, 1/128 deg)
//  out      | out_valid / out_ready | out_voltage, out_duty_count, out_range_flag
//  cfg      | cfg_valid / cfg_ready | cfg_index (2b), cfg_data (24b)
//
// an item whose phase lies at or beyond either table end skips the scan and the divider;
// inside the table it passes the one-entry-a-cycle table scan, over interval numbers up to
// 52, and once an interval matches the one-bit-a-cycle restoring divider
// one item at a time; the next item is taken once the last one sits in the result register
// a stalled result holds the block before its result load, cfg writes are always taken
// synchronous active-low reset restores the register defaults and empties the result stage
module phase_to_pwm_duty_converter import ppd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [PHASE_W-1:0] in_phase,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [VOLT_W-1:0]         out_voltage,
  output logic [COUNT_W-1:0]        out_duty_count,
  output logic [FLAG_W-1:0]         out_range_flag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  ppd_cmd_t    cmd;
  ppd_status_t st;

  assign cfg_ready = 1'b1;

  ppd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ppd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_phase       (in_phase),
    .out_voltage    (out_voltage),
    .out_duty_count (out_duty_count),
    .out_range_flag (out_range_flag)
  );

endmodule
